// ===== src/iee_pkg.sv =====
// Shared types, constants and helpers for the infix expression evaluator.
`timescale 1ns / 1ps

package iee_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 4;

    // Error codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_DIVZERO   = 3'd1;
    localparam logic [2:0] ERR_MALFORMED = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
    localparam logic [2:0] ERR_ILLEGAL   = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_MOD    = 3'd4,
        OP_POW    = 3'd5,
        OP_LPAREN = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        K_DIGIT,
        K_LETTER,
        K_SPACE,
        K_OPER,
        K_LPAREN,
        K_RPAREN,
        K_ILLEGAL,
        K_END
    } kind_t;

    // One classified item as it travels from front to back
    typedef struct packed {
        kind_t      kind;
        op_t        op;
        logic [3:0] digit;
    } cmd_t;

    typedef enum logic [1:0] {
        M_OPER,
        M_CLOSE,
        M_END
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOOP,
        S_TOPEVAL,
        S_POPB,
        S_POPA,
        S_CAPA,
        S_EXEC,
        S_DIV,
        S_DIVFIX,
        S_POW,
        S_PUSH,
        S_FIN,
        S_FINW
    } state_t;

    function automatic logic [1:0] level_of(op_t op);
        case (op)
            OP_ADD, OP_SUB: level_of = 2'd1;
            OP_MUL, OP_DIV: level_of = 2'd2;
            OP_MOD, OP_POW: level_of = 2'd3;
            default:        level_of = 2'd0;
        endcase
    endfunction

endpackage

// ===== src/iee_front.sv =====
// Input side: takes characters and classifies them into commands.
`timescale 1ns / 1ps

module iee_front
    import iee_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] char_code,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_wdata
);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Character classification
    always_comb
    begin
        q_wdata.kind  = K_ILLEGAL;
        q_wdata.op    = OP_ADD;
        q_wdata.digit = char_code[3:0];
        if (req_type)
        begin
            q_wdata.kind = K_END;
        end
        else if (char_code >= 8'h30 && char_code <= 8'h39)
        begin
            q_wdata.kind = K_DIGIT;
        end
        else if ((char_code >= 8'h61 && char_code <= 8'h7a) ||
                 (char_code >= 8'h41 && char_code <= 8'h5a))
        begin
            q_wdata.kind = K_LETTER;
        end
        else
        begin
            case (char_code)
                8'h20: q_wdata.kind = K_SPACE;
                8'h2b: begin q_wdata.kind = K_OPER; q_wdata.op = OP_ADD; end
                8'h2d: begin q_wdata.kind = K_OPER; q_wdata.op = OP_SUB; end
                8'h2a: begin q_wdata.kind = K_OPER; q_wdata.op = OP_MUL; end
                8'h2f: begin q_wdata.kind = K_OPER; q_wdata.op = OP_DIV; end
                8'h25: begin q_wdata.kind = K_OPER; q_wdata.op = OP_MOD; end
                8'h5e: begin q_wdata.kind = K_OPER; q_wdata.op = OP_POW; end
                8'h28: q_wdata.kind = K_LPAREN;
                8'h29: q_wdata.kind = K_RPAREN;
                default: q_wdata.kind = K_ILLEGAL;
            endcase
        end
    end

endmodule

// ===== src/iee_queue.sv =====
// Short command queue between the front and the evaluation engine.
`timescale 1ns / 1ps

module iee_queue
    import iee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t rdata
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [PTR_W:0]     fill_reg;

    assign full  = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign valid = (fill_reg != '0);
    assign rdata = slot_reg[rptr_reg];

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (PTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== src/iee_engine.sv =====
// Back end: token building, operator and operand stacks, arithmetic sequencer.
`timescale 1ns / 1ps

module iee_engine
    import iee_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cmd_t               q_rdata,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic [2:0]         error_code
);

    // Stack memories
    logic [2:0]  opr_mem [STACK_DEPTH];
    logic [31:0] opd_mem [STACK_DEPTH];
    logic [2:0]  opr_rdata;
    logic [31:0] opd_rdata;
    logic        opr_we, opd_we;
    logic [IDX_W-1:0] opr_waddr, opr_raddr, opd_waddr, opd_raddr;
    logic [2:0]  opr_wdata;
    logic [31:0] opd_wdata;

    always_ff @(posedge clk)
    begin
        if (opr_we)
        begin
            opr_mem[opr_waddr] <= opr_wdata;
        end
        opr_rdata <= opr_mem[opr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (opd_we)
        begin
            opd_mem[opd_waddr] <= opd_wdata;
        end
        opd_rdata <= opd_mem[opd_raddr];
    end

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    cmd_t              cmd_reg, cmd_next;
    op_t               aop_reg, aop_next;
    logic [31:0]       tok_reg, tok_next;
    logic              tok_act_reg, tok_act_next;
    logic              dig_open_reg, dig_open_next;
    logic [2:0]        err_reg, err_next;
    logic [CNT_W-1:0]  opr_cnt_reg, opr_cnt_next;
    logic [CNT_W-1:0]  opd_cnt_reg, opd_cnt_next;
    logic              bmiss_reg, bmiss_next;
    logic              amiss_reg, amiss_next;
    logic [31:0]       a_reg, a_next, b_reg, b_next, res_reg, res_next;
    logic [31:0]       quo_reg, quo_next, rem_reg, rem_next, den_reg, den_next;
    logic [4:0]        it_reg, it_next;
    logic [31:0]       base_reg, base_next, exp_reg, exp_next;
    logic              ov_reg, ov_next;
    logic [31:0]       ovalue_reg, ovalue_next;
    logic [2:0]        oerr_reg, oerr_next;

    logic [32:0]       rem_sh;
    logic [32:0]       rem_sub;
    op_t               top_op;

    assign out_valid  = ov_reg;
    assign value      = ovalue_reg;
    assign error_code = oerr_reg;
    assign top_op     = op_t'(opr_rdata);
    assign rem_sh     = {rem_reg, quo_reg[31]};
    assign rem_sub    = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tok_act_reg  <= 1'b0;
            dig_open_reg <= 1'b0;
            tok_reg      <= '0;
            err_reg      <= ERR_OK;
            opr_cnt_reg  <= '0;
            opd_cnt_reg  <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tok_act_reg  <= tok_act_next;
            dig_open_reg <= dig_open_next;
            tok_reg      <= tok_next;
            err_reg      <= err_next;
            opr_cnt_reg  <= opr_cnt_next;
            opd_cnt_reg  <= opd_cnt_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        cmd_reg    <= cmd_next;
        aop_reg    <= aop_next;
        bmiss_reg  <= bmiss_next;
        amiss_reg  <= amiss_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        res_reg    <= res_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        it_reg     <= it_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        ovalue_reg <= ovalue_next;
        oerr_reg   <= oerr_next;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        cmd_next      = cmd_reg;
        aop_next      = aop_reg;
        tok_next      = tok_reg;
        tok_act_next  = tok_act_reg;
        dig_open_next = dig_open_reg;
        err_next      = err_reg;
        opr_cnt_next  = opr_cnt_reg;
        opd_cnt_next  = opd_cnt_reg;
        bmiss_next    = bmiss_reg;
        amiss_next    = amiss_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        res_next      = res_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        it_next       = it_reg;
        base_next     = base_reg;
        exp_next      = exp_reg;
        ov_next       = ov_reg;
        ovalue_next   = ovalue_reg;
        oerr_next     = oerr_reg;
        q_pop         = 1'b0;
        opr_we        = 1'b0;
        opr_waddr     = opr_cnt_reg[IDX_W-1:0];
        opr_wdata     = cmd_reg.op;
        opr_raddr     = '0;
        opd_we        = 1'b0;
        opd_waddr     = opd_cnt_reg[IDX_W-1:0];
        opd_wdata     = res_reg;
        opd_raddr     = '0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_rdata.kind)
                        K_DIGIT:
                        begin
                            if (!tok_act_reg)
                            begin
                                tok_act_next  = 1'b1;
                                dig_open_next = 1'b1;
                                tok_next      = {28'd0, q_rdata.digit};
                            end
                            else if (dig_open_reg)
                            begin
                                tok_next = (tok_reg << 3) + (tok_reg << 1)
                                         + {28'd0, q_rdata.digit};
                            end
                        end
                        K_LETTER:
                        begin
                            if (!tok_act_reg)
                            begin
                                tok_act_next = 1'b1;
                                tok_next     = '0;
                            end
                            dig_open_next = 1'b0;
                        end
                        default:
                        begin
                            // Close a pending token
                            if (tok_act_reg)
                            begin
                                if (opd_cnt_reg == CNT_W'(STACK_DEPTH))
                                begin
                                    if (err_reg == ERR_OK) err_next = ERR_OVERFLOW;
                                end
                                else
                                begin
                                    opd_we       = 1'b1;
                                    opd_wdata    = tok_reg;
                                    opd_cnt_next = opd_cnt_reg + CNT_W'(1);
                                end
                            end
                            tok_act_next  = 1'b0;
                            dig_open_next = 1'b0;
                            tok_next      = '0;
                            cmd_next      = q_rdata;
                            state_next    = S_DISPATCH;
                        end
                    endcase
                end
            end

            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (cmd_reg.kind)
                    K_ILLEGAL:
                    begin
                        if (err_reg == ERR_OK) err_next = ERR_ILLEGAL;
                    end
                    K_LPAREN:
                    begin
                        if (opr_cnt_reg == CNT_W'(STACK_DEPTH))
                        begin
                            if (err_reg == ERR_OK) err_next = ERR_OVERFLOW;
                        end
                        else
                        begin
                            opr_we       = 1'b1;
                            opr_wdata    = OP_LPAREN;
                            opr_cnt_next = opr_cnt_reg + CNT_W'(1);
                        end
                    end
                    K_OPER:
                    begin
                        mode_next  = M_OPER;
                        state_next = S_LOOP;
                    end
                    K_RPAREN:
                    begin
                        mode_next  = M_CLOSE;
                        state_next = S_LOOP;
                    end
                    K_END:
                    begin
                        mode_next  = M_END;
                        state_next = S_LOOP;
                    end
                    default: state_next = S_IDLE;
                endcase
            end

            // Head of the operator pop loop
            S_LOOP:
            begin
                if (opr_cnt_reg == '0)
                begin
                    case (mode_reg)
                        M_OPER:
                        begin
                            opr_we       = 1'b1;
                            opr_cnt_next = opr_cnt_reg + CNT_W'(1);
                            state_next   = S_IDLE;
                        end
                        M_CLOSE:
                        begin
                            if (err_reg == ERR_OK) err_next = ERR_MALFORMED;
                            state_next = S_IDLE;
                        end
                        default: state_next = S_FIN;
                    endcase
                end
                else
                begin
                    opr_raddr  = IDX_W'(opr_cnt_reg - CNT_W'(1));
                    state_next = S_TOPEVAL;
                end
            end

            S_TOPEVAL:
            begin
                aop_next = top_op;
                case (mode_reg)
                    M_OPER:
                    begin
                        if (top_op == OP_LPAREN || level_of(top_op) < level_of(cmd_reg.op))
                        begin
                            if (opr_cnt_reg == CNT_W'(STACK_DEPTH))
                            begin
                                if (err_reg == ERR_OK) err_next = ERR_OVERFLOW;
                            end
                            else
                            begin
                                opr_we       = 1'b1;
                                opr_cnt_next = opr_cnt_reg + CNT_W'(1);
                            end
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            opr_cnt_next = opr_cnt_reg - CNT_W'(1);
                            state_next   = S_POPB;
                        end
                    end
                    M_CLOSE:
                    begin
                        opr_cnt_next = opr_cnt_reg - CNT_W'(1);
                        state_next   = (top_op == OP_LPAREN) ? S_IDLE : S_POPB;
                    end
                    default:
                    begin
                        opr_cnt_next = opr_cnt_reg - CNT_W'(1);
                        if (top_op == OP_LPAREN)
                        begin
                            if (err_reg == ERR_OK) err_next = ERR_MALFORMED;
                            state_next = S_LOOP;
                        end
                        else
                        begin
                            state_next = S_POPB;
                        end
                    end
                endcase
            end

            // Operand pops: missing operands read as zero
            S_POPB:
            begin
                if (opd_cnt_reg == '0)
                begin
                    bmiss_next = 1'b1;
                    if (err_reg == ERR_OK) err_next = ERR_MALFORMED;
                end
                else
                begin
                    bmiss_next   = 1'b0;
                    opd_raddr    = IDX_W'(opd_cnt_reg - CNT_W'(1));
                    opd_cnt_next = opd_cnt_reg - CNT_W'(1);
                end
                state_next = S_POPA;
            end

            S_POPA:
            begin
                b_next = bmiss_reg ? 32'd0 : opd_rdata;
                if (opd_cnt_reg == '0)
                begin
                    amiss_next = 1'b1;
                    if (err_reg == ERR_OK) err_next = ERR_MALFORMED;
                end
                else
                begin
                    amiss_next   = 1'b0;
                    opd_raddr    = IDX_W'(opd_cnt_reg - CNT_W'(1));
                    opd_cnt_next = opd_cnt_reg - CNT_W'(1);
                end
                state_next = S_CAPA;
            end

            S_CAPA:
            begin
                a_next     = amiss_reg ? 32'd0 : opd_rdata;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                state_next = S_PUSH;
                case (aop_reg)
                    OP_ADD: res_next = a_reg + b_reg;
                    OP_SUB: res_next = a_reg - b_reg;
                    OP_MUL: res_next = a_reg * b_reg;
                    OP_DIV, OP_MOD:
                    begin
                        if (b_reg == '0)
                        begin
                            res_next = '0;
                            if (err_reg == ERR_OK) err_next = ERR_DIVZERO;
                        end
                        else
                        begin
                            quo_next   = a_reg[31] ? (32'd0 - a_reg) : a_reg;
                            den_next   = b_reg[31] ? (32'd0 - b_reg) : b_reg;
                            rem_next   = '0;
                            it_next    = '0;
                            state_next = S_DIV;
                        end
                    end
                    OP_POW:
                    begin
                        res_next = 32'd1;
                        if (!b_reg[31])
                        begin
                            base_next  = a_reg;
                            exp_next   = b_reg;
                            state_next = S_POW;
                        end
                    end
                    default: res_next = '0;
                endcase
            end

            // Restoring division, one quotient bit per cycle
            S_DIV:
            begin
                if (!rem_sub[32])
                begin
                    rem_next = rem_sub[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                it_next = it_reg + 5'd1;
                if (it_reg == 5'd31)
                begin
                    state_next = S_DIVFIX;
                end
            end

            // Signs: quotient by both operands, remainder follows the dividend
            S_DIVFIX:
            begin
                if (aop_reg == OP_DIV)
                begin
                    res_next = (a_reg[31] ^ b_reg[31]) ? (32'd0 - quo_reg) : quo_reg;
                end
                else
                begin
                    res_next = a_reg[31] ? (32'd0 - rem_reg) : rem_reg;
                end
                state_next = S_PUSH;
            end

            // Power by squaring, one exponent bit per cycle
            S_POW:
            begin
                if (exp_reg == '0)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    if (exp_reg[0])
                    begin
                        res_next = res_reg * base_reg;
                    end
                    base_next = base_reg * base_reg;
                    exp_next  = {1'b0, exp_reg[31:1]};
                end
            end

            S_PUSH:
            begin
                if (opd_cnt_reg == CNT_W'(STACK_DEPTH))
                begin
                    if (err_reg == ERR_OK) err_next = ERR_OVERFLOW;
                end
                else
                begin
                    opd_we       = 1'b1;
                    opd_cnt_next = opd_cnt_reg + CNT_W'(1);
                end
                state_next = S_LOOP;
            end

            S_FIN:
            begin
                if (opd_cnt_reg != CNT_W'(1))
                begin
                    if (err_reg == ERR_OK) err_next = ERR_MALFORMED;
                end
                state_next = S_FINW;
            end

            // Hand the result to the output register, then clear the state
            S_FINW:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next      = 1'b1;
                    ovalue_next  = (opd_cnt_reg != '0) ? opd_rdata : 32'd0;
                    oerr_next    = err_reg;
                    err_next     = ERR_OK;
                    opd_cnt_next = '0;
                    opr_cnt_next = '0;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== src/infix_expression_evaluator.sv =====
// Top level of the infix expression evaluator: front, queue and engine.
`timescale 1ns / 1ps
//
// Characters of an infix integer expression enter on the input channel
// (in_valid / in_stall, with req_type and char_code); a transfer with
// req_type = 1 ends the expression. Each end request gives one transfer
// on the output channel (out_valid / out_stall, with value and error_code);
// characters give none.
// The front classifies each character in the cycle of its transfer and
// places it in a four-entry queue; in_stall rises only when that queue is
// full. The engine drains the queue: a letter or digit extends the token,
// while any other item closes a pending token and is then dispatched. An
// operator pops and applies stacked operators of equal or higher level, a
// ')' those back to its '(', and an end request all of them. A divide or
// remainder runs one quotient bit per cycle and then a sign fix, a power
// one exponent bit per cycle. The single stack sequencer does all of this.
// Reset clears the counts, token, error and queue; no clearing pass.
// While out_stall is high a finished result holds in the output register
// and the engine keeps working until the next result is ready.
//

module infix_expression_evaluator
    import iee_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic [2:0]         error_code
);

    logic q_full, q_push, q_pop, q_valid;
    cmd_t q_wdata, q_rdata;

    iee_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .char_code (char_code),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    iee_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    iee_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_rdata    (q_rdata),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .error_code (error_code)
    );

endmodule

// ===== tb/infix_expression_evaluator_tb.sv =====
// Self-checking testbench for the infix expression evaluator.
`timescale 1ns / 1ps

module infix_expression_evaluator_tb;
    import iee_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic [7:0]         char_code;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] value;
    logic [2:0]         error_code;

    infix_expression_evaluator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .char_code(char_code),
        .out_valid(out_valid), .out_stall(out_stall),
        .value(value), .error_code(error_code)
    );

    typedef struct {
        logic [31:0] val;
        logic [2:0]  err;
    } answer_t;

    // Shadow state of the evaluator
    op_t         ops [STACK_DEPTH];
    int          op_cnt;
    logic [31:0] nums [STACK_DEPTH];
    int          num_cnt;
    logic [31:0] tok_val;
    bit          tok_on;
    bit          tok_digits;
    logic [2:0]  err_st;

    answer_t answers [$];
    int      failures;
    int      hold_cycles;
    int      rx_wait;
    bit      rx_random;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int lvl(op_t op);
        case (op)
            OP_ADD, OP_SUB: return 1;
            OP_MUL, OP_DIV: return 2;
            OP_MOD, OP_POW: return 3;
            default:        return 0;
        endcase
    endfunction

    function automatic void flag(logic [2:0] code);
        if (err_st == ERR_OK)
            err_st = code;
    endfunction

    function automatic void clear_state();
        op_cnt = 0;
        num_cnt = 0;
        tok_val = '0;
        tok_on = 0;
        tok_digits = 0;
        err_st = ERR_OK;
    endfunction

    function automatic void push_num(logic [31:0] v);
        if (num_cnt >= STACK_DEPTH)
        begin
            flag(ERR_OVERFLOW);
            return;
        end
        nums[num_cnt] = v;
        num_cnt++;
    endfunction

    function automatic logic [31:0] pop_num();
        if (num_cnt == 0)
        begin
            flag(ERR_MALFORMED);
            return '0;
        end
        num_cnt--;
        return nums[num_cnt];
    endfunction

    function automatic void push_op(op_t op);
        if (op_cnt >= STACK_DEPTH)
        begin
            flag(ERR_OVERFLOW);
            return;
        end
        ops[op_cnt] = op;
        op_cnt++;
    endfunction

    function automatic logic [31:0] raise_pow(logic [31:0] b, logic [31:0] e);
        logic [31:0] r;
        r = 32'd1;
        if (e[31])
            return r;
        while (e != 0)
        begin
            if (e[0])
                r = r * b;
            b = b * b;
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic void apply_op(op_t op);
        logic [31:0]        b;
        logic [31:0]        a;
        logic [31:0]        r;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        b = pop_num();
        a = pop_num();
        r = '0;
        sa = a;
        sb = b;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV:
                if (b == 0) flag(ERR_DIVZERO);
                else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r = a;
                else r = sa / sb;
            OP_MOD:
                if (b == 0) flag(ERR_DIVZERO);
                else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r = '0;
                else r = sa % sb;
            OP_POW: r = raise_pow(a, b);
            default: ;
        endcase
        push_num(r);
    endfunction

    function automatic void end_token();
        if (tok_on)
            push_num(tok_val);
        tok_on = 0;
        tok_digits = 0;
        tok_val = '0;
    endfunction

    function automatic void take_op(op_t op);
        op_t top;
        while (op_cnt > 0)
        begin
            top = ops[op_cnt - 1];
            if (top == OP_LPAREN || lvl(top) < lvl(op))
                break;
            op_cnt--;
            apply_op(top);
        end
        push_op(op);
    endfunction

    function automatic void take_close();
        op_t top;
        while (op_cnt > 0)
        begin
            op_cnt--;
            top = ops[op_cnt];
            if (top == OP_LPAREN)
                return;
            apply_op(top);
        end
        flag(ERR_MALFORMED);
    endfunction

    // Predict one accepted item; an end request queues one answer
    function automatic void predict_item(logic rt, logic [7:0] c);
        bit      dig;
        bit      let_c;
        answer_t ans;
        op_t     top;
        if (!rt)
        begin
            dig = c >= "0" && c <= "9";
            let_c = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
            if (dig || let_c)
            begin
                if (!tok_on)
                begin
                    tok_on = 1;
                    tok_val = '0;
                    tok_digits = dig;
                end
                if (dig && tok_digits)
                    tok_val = tok_val * 10 + 32'(c - "0");
                else
                    tok_digits = 0;
                return;
            end
            end_token();
            case (c)
                " ": ;
                "+": take_op(OP_ADD);
                "-": take_op(OP_SUB);
                "*": take_op(OP_MUL);
                "/": take_op(OP_DIV);
                "%": take_op(OP_MOD);
                "^": take_op(OP_POW);
                "(": push_op(OP_LPAREN);
                ")": take_close();
                default: flag(ERR_ILLEGAL);
            endcase
            return;
        end
        end_token();
        while (op_cnt > 0)
        begin
            op_cnt--;
            top = ops[op_cnt];
            if (top == OP_LPAREN)
                flag(ERR_MALFORMED);
            else
                apply_op(top);
        end
        if (num_cnt != 1)
            flag(ERR_MALFORMED);
        ans.val = num_cnt > 0 ? nums[0] : '0;
        ans.err = err_st;
        answers.push_back(ans);
        clear_state();
    endfunction

    // Send one item, with a random lead-in gap if gaps is set; valid drops only during a gap
    task automatic send_item(logic rt, logic [7:0] c, bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= rt;
        char_code <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_item(rt, c);
    endtask

    task automatic send_text(string s, bit gaps = 1);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, s[i], gaps);
        send_item(1'b1, 8'($urandom_range(0, 255)), gaps);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (answers.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Receiver: random wait after each result, or a forced long hold
    always @(posedge clk)
    begin
        int w;
        w = $urandom_range(0, 7);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            out_stall <= 1'b1;
        end
        else if (rx_random && out_valid && !out_stall && w > 0)
        begin
            rx_wait <= w - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Result checker
    always @(posedge clk)
    begin
        answer_t ex;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answers.size() == 0)
            begin
                $error("unexpected result value=%h error_code=%0d", value, error_code);
                failures++;
            end
            else
            begin
                ex = answers.pop_front();
                if (value !== ex.val)
                begin
                    $error("value: expected %h actual %h", ex.val, value);
                    failures++;
                end
                if (error_code !== ex.err)
                begin
                    $error("error_code: expected %0d actual %0d", ex.err, error_code);
                    failures++;
                end
            end
        end
    end

    task automatic test_directed();
        send_text("1+2*3");
        send_text("(1+2)*3-4/2");
        send_text("2^10%7");
        send_text("4294967295+1");
        send_text("99999999999");
        send_text("abc+12x3");
        send_text("5/0");
        send_text("5%0");
        send_text("2147483648/ 4294967295");
        send_text("2147483648%4294967295");
        send_text("0-2147483648-1");
        send_text("3^(0-1)");
        send_text("7-3-2");
        send_text("((1)");
        send_text("1)");
        send_text("+");
        send_text("1 2");
        send_text("");
        send_text("1#2");
        send_text("1/0#");
        send_text("Zz9 ~");
        wait_drained();
    endtask

    // Deep nesting fills both stacks past their depth
    task automatic test_overflow();
        string s;
        s = "";
        for (int i = 0; i < STACK_DEPTH + 3; i++) s = {s, "("};
        send_text({s, "1"});
        s = "";
        for (int i = 0; i < STACK_DEPTH + 2; i++) s = {s, "1+(2*"};
        send_text(s);
        wait_drained();
    endtask

    function automatic string rand_expr(int depth);
        string s;
        string ops_s;
        int    n;
        ops_s = "+-*/%^";
        n = $urandom_range(1, 4);
        s = "";
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                s = {s, string'(ops_s[$urandom_range(0, 5)])};
                if ($urandom_range(0, 3) == 0) s = {s, " "};
            end
            if (depth > 0 && $urandom_range(0, 3) == 0)
                s = {s, "(", rand_expr(depth - 1), ")"};
            else
                case ($urandom_range(0, 5))
                    0: s = {s, $sformatf("%0d", $urandom)};
                    1: s = {s, $sformatf("%0d", $urandom_range(0, 3))};
                    2: s = {s, "x", $sformatf("%0d", $urandom_range(0, 9))};
                    default: s = {s, $sformatf("%0d", $urandom_range(0, 99))};
                endcase
        end
        return s;
    endfunction

    task automatic test_random();
        int sent;
        string s;
        sent = 0;
        while (sent < 400)
        begin
            if ($urandom_range(0, 9) < 8)
                s = rand_expr(2);
            else
            begin
                s = "";
                repeat ($urandom_range(0, 12))
                    s = {s, string'(byte'($urandom_range(0, 255)))};
            end
            send_text(s, $urandom_range(0, 3) != 0);
            sent += s.len() + 1;
        end
        wait_drained();
    endtask

    // Long receiver hold while the sender keeps going
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 6; i++)
            send_text("12*(3+4)/5", 0);
        wait_drained();
    endtask

    initial
    begin
        failures = 0;
        hold_cycles = 0;
        rx_wait = 0;
        rx_random = 1;
        clear_state();
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = 1'b0;
        char_code = 8'd0;
        out_stall = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
